// File: src/mwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwt_pkg
// Shared types and constants of the markup word tokenizer: record layout,
// token and case codes, scanner state and the record group of one byte.
// ----------------------------------------------------------------------------
package mwt_pkg;

  localparam int MAX_TOKEN_LEN = 4095;
  localparam int LEN_W         = 12;
  localparam int LEN_CAP_INT   = (MAX_TOKEN_LEN > 4095) ? 4095 : MAX_TOKEN_LEN;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_INT[LEN_W-1:0];

  localparam logic [7:0] LEAD_BYTE = 8'hC3;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  localparam logic REC_CONTENT = 1'b0;
  localparam logic REC_END     = 1'b1;

  // records one byte can produce, spill included, before capping
  localparam int SLOTS    = 5;
  localparam int GRP_RECS = 3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_SYM  = 2'd2,
    MODE_CMD  = 2'd3
  } scan_mode_t;

  typedef enum logic [1:0] {
    TK_WORD   = 2'd0,
    TK_SYM    = 2'd1,
    TK_CMD    = 2'd2,
    TK_ENDCMD = 2'd3
  } tok_kind_t;

  typedef enum logic [1:0] {
    CC_UPPER    = 2'd0,
    CC_LOWER    = 2'd1,
    CC_SENTENCE = 2'd2,
    CC_MIXED    = 2'd3
  } case_class_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    tok_kind_t         tkind;
    case_class_t       cclass;
    logic [LEN_W-1:0]  len;
  } rec_t;

  typedef struct packed {
    scan_mode_t        mode;
    logic              held;
    logic [LEN_W-1:0]  count;
    logic              up;
    logic              lo;
    logic              sent;
    logic              closing;
  } tst_t;

  typedef struct packed {
    rec_t [GRP_RECS-1:0] recs;
    logic [1:0]          n;
  } grp_t;

endpackage

// File: src/markup_word_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_word_tokenizer
// Byte-stream lexer that splits text into words, symbols and commands.
// ----------------------------------------------------------------------------
// A byte is taken into an input register and classified combinationally
// against the scanner state; its records (zero to three) are written to a
// result register. The output side sends one record per beat: a byte that
// yields one record or none keeps the full rate of one byte per cycle while
// the output does not stall; a byte that yields two or three records holds
// the input while the result register drains. Each content byte comes out
// tagged with its token kind, and every finished token adds an end record
// with its length (saturating at 4095) and, for words, its case class; last
// marks a byte's final record. The rare fourth record of a byte is kept and
// sent ahead of the next byte's records.
module markup_word_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        record_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  token_kind,
  output logic [1:0]  case_class,
  output logic [11:0] token_length,
  output logic        last
);

  logic          item_valid;
  logic [7:0]    item_byte;
  logic          item_eos;
  mwt_pkg::tst_t st;
  mwt_pkg::tst_t st_next;
  logic          spill_valid;
  logic          spill_valid_next;
  mwt_pkg::rec_t spill;
  mwt_pkg::rec_t spill_next;
  mwt_pkg::grp_t grp;
  logic          grp_free;
  logic          fire;
  logic          accept;

  assign fire     = item_valid && grp_free;
  assign in_stall = item_valid && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte <= in_byte;
      item_eos  <= end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode     <= mwt_pkg::MODE_IDLE;
      st.held     <= 1'b0;
      st.count    <= '0;
      st.up       <= 1'b0;
      st.lo       <= 1'b0;
      st.sent     <= 1'b0;
      st.closing  <= 1'b0;
      spill_valid <= 1'b0;
    end else if (fire) begin
      st          <= st_next;
      spill_valid <= spill_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      spill <= spill_next;
    end
  end

  mwt_step u_step (
    .st_cur           (st),
    .spill_valid      (spill_valid),
    .spill            (spill),
    .data_byte        (item_byte),
    .eos              (item_eos),
    .st_next          (st_next),
    .grp              (grp),
    .spill_valid_next (spill_valid_next),
    .spill_next       (spill_next)
  );

  mwt_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (fire && (grp.n != 2'd0)),
    .grp_in       (grp),
    .free         (grp_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .record_kind  (record_kind),
    .out_byte     (out_byte),
    .token_kind   (token_kind),
    .case_class   (case_class),
    .token_length (token_length),
    .last         (last)
  );

endmodule

// File: src/mwt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwt_step
// Classifies one byte against the scanner state and builds the records it
// causes, the next scanner state and the spill record for the next beat.
// ----------------------------------------------------------------------------
module mwt_step (
  input  mwt_pkg::tst_t st_cur,
  input  logic          spill_valid,
  input  mwt_pkg::rec_t spill,
  input  logic [7:0]    data_byte,
  input  logic          eos,
  output mwt_pkg::tst_t st_next,
  output mwt_pkg::grp_t grp,
  output logic          spill_valid_next,
  output mwt_pkg::rec_t spill_next
);

  typedef struct packed {
    mwt_pkg::tst_t                       st;
    mwt_pkg::rec_t [mwt_pkg::SLOTS-1:0]  recs;
    logic [2:0]                          n;
  } wk_t;

  function automatic mwt_pkg::rec_t mk_rec(logic kind, logic [7:0] d,
                                           mwt_pkg::tok_kind_t tk,
                                           mwt_pkg::case_class_t cc,
                                           logic [mwt_pkg::LEN_W-1:0] len);
    mwt_pkg::rec_t r;
    r.kind   = kind;
    r.data   = d;
    r.tkind  = tk;
    r.cclass = cc;
    r.len    = len;
    return r;
  endfunction

  function automatic wk_t put(wk_t w, mwt_pkg::rec_t r);
    wk_t o;
    o = w;
    if (w.n < 3'(mwt_pkg::SLOTS)) begin
      o.recs[w.n] = r;
      o.n = w.n + 3'd1;
    end
    return o;
  endfunction

  function automatic wk_t bump(wk_t w);
    wk_t o;
    o = w;
    if (w.st.count < mwt_pkg::LEN_CAP) begin
      o.st.count = w.st.count + 1'b1;
    end
    return o;
  endfunction

  function automatic logic acc_upper(logic [7:0] b);
    return b inside {8'h81, 8'h89, 8'h8D, 8'h93, 8'h9A, 8'h9C, 8'h91};
  endfunction

  function automatic logic acc_lower(logic [7:0] b);
    return b inside {8'hA1, 8'hA9, 8'hAD, 8'hB3, 8'hBA, 8'hBC, 8'hB1};
  endfunction

  function automatic wk_t end_token(wk_t w);
    wk_t o;
    mwt_pkg::case_class_t cc;
    o = w;
    cc = w.st.up ? mwt_pkg::CC_UPPER :
         w.st.lo ? mwt_pkg::CC_LOWER :
         w.st.sent ? mwt_pkg::CC_SENTENCE : mwt_pkg::CC_MIXED;
    case (w.st.mode)
      mwt_pkg::MODE_WORD: begin
        o = put(o, mk_rec(mwt_pkg::REC_END, 8'h00, mwt_pkg::TK_WORD, cc, w.st.count));
      end
      mwt_pkg::MODE_SYM: begin
        o = put(o, mk_rec(mwt_pkg::REC_END, 8'h00, mwt_pkg::TK_SYM,
                          mwt_pkg::CC_UPPER, w.st.count));
      end
      mwt_pkg::MODE_CMD: begin
        if (w.st.count != '0) begin
          o = put(o, mk_rec(mwt_pkg::REC_END, 8'h00,
                            w.st.closing ? mwt_pkg::TK_ENDCMD : mwt_pkg::TK_CMD,
                            mwt_pkg::CC_UPPER, w.st.count));
        end
      end
      default: begin
      end
    endcase
    o.st.mode    = mwt_pkg::MODE_IDLE;
    o.st.count   = '0;
    o.st.up      = 1'b0;
    o.st.lo      = 1'b0;
    o.st.sent    = 1'b0;
    o.st.closing = 1'b0;
    return o;
  endfunction

  function automatic wk_t word_add(wk_t w, logic [7:0] b0, logic [7:0] b1,
                                   logic two, logic up, logic lo);
    wk_t o;
    o = w;
    if (w.st.mode != mwt_pkg::MODE_WORD) begin
      o = end_token(o);
      o.st.mode = mwt_pkg::MODE_WORD;
      o.st.up   = up;
      o.st.lo   = lo;
      o.st.sent = up;
    end else begin
      o.st.up   = w.st.up && up;
      o.st.lo   = w.st.lo && lo;
      o.st.sent = w.st.sent && lo;
    end
    o = put(o, mk_rec(mwt_pkg::REC_CONTENT, b0, mwt_pkg::TK_WORD, mwt_pkg::CC_UPPER, '0));
    o = bump(o);
    if (two) begin
      o = put(o, mk_rec(mwt_pkg::REC_CONTENT, b1, mwt_pkg::TK_WORD,
                        mwt_pkg::CC_UPPER, '0));
      o = bump(o);
    end
    return o;
  endfunction

  function automatic wk_t sym_byte(wk_t w, logic [7:0] b);
    wk_t o;
    o = w;
    if (w.st.mode != mwt_pkg::MODE_SYM) begin
      o = end_token(o);
      o.st.mode = mwt_pkg::MODE_SYM;
    end
    o = put(o, mk_rec(mwt_pkg::REC_CONTENT, b, mwt_pkg::TK_SYM, mwt_pkg::CC_UPPER, '0));
    o = bump(o);
    return o;
  endfunction

  function automatic wk_t plain(wk_t w, logic [7:0] b);
    wk_t o;
    o = w;
    if (b == mwt_pkg::LEAD_BYTE) begin
      o.st.held = 1'b1;
    end else if (b >= mwt_pkg::CH_UP_A && b <= mwt_pkg::CH_UP_Z) begin
      o = word_add(o, b, 8'h00, 1'b0, 1'b1, 1'b0);
    end else if (b >= mwt_pkg::CH_LO_A && b <= mwt_pkg::CH_LO_Z) begin
      o = word_add(o, b, 8'h00, 1'b0, 1'b0, 1'b1);
    end else if (b == mwt_pkg::CH_LT) begin
      o = end_token(o);
      o.st.mode = mwt_pkg::MODE_CMD;
    end else begin
      o = sym_byte(o, b);
    end
    return o;
  endfunction

  wk_t w;
  logic au;
  logic al;

  assign au = acc_upper(data_byte);
  assign al = acc_lower(data_byte);

  always_comb begin
    w = '0;
    w.st = st_cur;
    if (spill_valid) begin
      w = put(w, spill);
    end
    if (eos) begin
      if (st_cur.held) begin
        w.st.held = 1'b0;
        w = sym_byte(w, mwt_pkg::LEAD_BYTE);
      end
      w = end_token(w);
    end else if (st_cur.mode == mwt_pkg::MODE_CMD) begin
      if (data_byte == mwt_pkg::CH_GT) begin
        w = end_token(w);
      end else begin
        if (st_cur.count == '0) begin
          w.st.closing = (data_byte == mwt_pkg::CH_SLASH);
        end
        w = put(w, mk_rec(mwt_pkg::REC_CONTENT, data_byte,
                          w.st.closing ? mwt_pkg::TK_ENDCMD : mwt_pkg::TK_CMD,
                          mwt_pkg::CC_UPPER, '0));
        w = bump(w);
      end
    end else if (st_cur.held) begin
      w.st.held = 1'b0;
      if (au || al) begin
        w = word_add(w, mwt_pkg::LEAD_BYTE, data_byte, 1'b1, au, al);
      end else begin
        w = sym_byte(w, mwt_pkg::LEAD_BYTE);
        w = plain(w, data_byte);
      end
    end else begin
      w = plain(w, data_byte);
    end
  end

  always_comb begin
    st_next          = w.st;
    grp.recs         = w.recs[mwt_pkg::GRP_RECS-1:0];
    grp.n            = (w.n > 3'(mwt_pkg::GRP_RECS)) ? 2'(mwt_pkg::GRP_RECS) : w.n[1:0];
    spill_valid_next = (w.n > 3'(mwt_pkg::GRP_RECS));
    spill_next       = w.recs[mwt_pkg::GRP_RECS];
  end

endmodule

// File: src/mwt_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwt_out
// Result register holding the record group of one byte; sends its records
// one beat at a time and marks the final one.
// ----------------------------------------------------------------------------
module mwt_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  mwt_pkg::grp_t grp_in,
  output logic          free,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          record_kind,
  output logic [7:0]    out_byte,
  output logic [1:0]    token_kind,
  output logic [1:0]    case_class,
  output logic [11:0]   token_length,
  output logic          last
);

  mwt_pkg::grp_t grp;
  logic          grp_valid;
  logic [1:0]    idx;
  mwt_pkg::rec_t rec;
  logic          take;
  logic          pop;

  always_comb begin
    case (idx)
      2'd0:    rec = grp.recs[0];
      2'd1:    rec = grp.recs[1];
      default: rec = grp.recs[2];
    endcase
  end

  assign last         = (idx == grp.n - 2'd1);
  assign take         = grp_valid && !out_stall;
  assign pop          = take && last;
  assign free         = !grp_valid || pop;
  assign out_valid    = grp_valid;
  assign record_kind  = rec.kind;
  assign out_byte     = rec.data;
  assign token_kind   = rec.tkind;
  assign case_class   = rec.cclass;
  assign token_length = rec.len;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      grp_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (pop) begin
      grp_valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule

// File: tb/mwt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwt_checker
// Watches both channels of the markup word tokenizer. Every accepted input
// beat runs through a lexer model that queues the records it should produce;
// every accepted output beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module mwt_checker
  import mwt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_stream,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        record_kind,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  token_kind,
  input  logic [1:0]  case_class,
  input  logic [11:0] token_length,
  input  logic        last,
  output int          pending,
  output int          fail_count
);

  typedef struct packed {
    rec_t rec;
    logic last;
  } due_rec_t;

  due_rec_t   due_records [$];
  int         mismatches = 0;

  scan_mode_t mode;
  logic       held;
  logic [LEN_W-1:0] count;
  logic       up;
  logic       lo;
  logic       sent;
  logic       closing;
  rec_t       spill_rec;
  logic       spill_ok;

  rec_t       step_recs [6];
  int         step_n;

  function automatic logic is_accent_upper(input logic [7:0] b);
    case (b)
      8'h81, 8'h89, 8'h8D, 8'h93, 8'h9A, 8'h9C, 8'h91: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_accent_lower(input logic [7:0] b);
    case (b)
      8'hA1, 8'hA9, 8'hAD, 8'hB3, 8'hBA, 8'hBC, 8'hB1: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit(input logic kind, input logic [7:0] data, input tok_kind_t tk,
                               input case_class_t cc, input logic [LEN_W-1:0] len);
    rec_t r;
    r.kind   = kind;
    r.data   = data;
    r.tkind  = tk;
    r.cclass = cc;
    r.len    = len;
    if (step_n < 6) begin
      step_recs[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void count_up();
    if (count < LEN_CAP) count++;
  endfunction

  function automatic void close_token();
    case (mode)
      MODE_WORD: begin
        emit(REC_END, 8'h00, TK_WORD,
             up ? CC_UPPER : lo ? CC_LOWER : sent ? CC_SENTENCE : CC_MIXED, count);
      end
      MODE_SYM: begin
        emit(REC_END, 8'h00, TK_SYM, CC_UPPER, count);
      end
      MODE_CMD: begin
        if (count != 0) emit(REC_END, 8'h00, closing ? TK_ENDCMD : TK_CMD, CC_UPPER, count);
      end
      default: ;
    endcase
    mode    = MODE_IDLE;
    count   = '0;
    up      = 1'b0;
    lo      = 1'b0;
    sent    = 1'b0;
    closing = 1'b0;
  endfunction

  function automatic void add_letter(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic two, input logic is_up, input logic is_lo);
    if (mode != MODE_WORD) begin
      close_token();
      mode = MODE_WORD;
      up   = is_up;
      lo   = is_lo;
      sent = is_up;
    end else begin
      up   = up && is_up;
      lo   = lo && is_lo;
      sent = sent && is_lo;
    end
    emit(REC_CONTENT, b0, TK_WORD, CC_UPPER, '0);
    count_up();
    if (two) begin
      emit(REC_CONTENT, b1, TK_WORD, CC_UPPER, '0);
      count_up();
    end
  endfunction

  function automatic void add_symbol(input logic [7:0] b);
    if (mode != MODE_SYM) begin
      close_token();
      mode = MODE_SYM;
    end
    emit(REC_CONTENT, b, TK_SYM, CC_UPPER, '0);
    count_up();
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    if (b == LEAD_BYTE) begin
      held = 1'b1;
    end else if (b >= CH_UP_A && b <= CH_UP_Z) begin
      add_letter(b, 8'h00, 1'b0, 1'b1, 1'b0);
    end else if (b >= CH_LO_A && b <= CH_LO_Z) begin
      add_letter(b, 8'h00, 1'b0, 1'b0, 1'b1);
    end else if (b == CH_LT) begin
      close_token();
      mode = MODE_CMD;
    end else begin
      add_symbol(b);
    end
  endfunction

  // one input beat: work out its records, keep a fourth one for the next beat
  function automatic void lex_step(input logic [7:0] b, input logic eos);
    int n;
    due_rec_t d;
    step_n = 0;
    if (spill_ok) begin
      step_recs[0] = spill_rec;
      step_n       = 1;
      spill_ok     = 1'b0;
    end
    if (eos) begin
      if (held) begin
        held = 1'b0;
        add_symbol(LEAD_BYTE);
      end
      close_token();
    end else if (mode == MODE_CMD) begin
      if (b == CH_GT) begin
        close_token();
      end else begin
        if (count == 0) closing = (b == CH_SLASH);
        emit(REC_CONTENT, b, closing ? TK_ENDCMD : TK_CMD, CC_UPPER, '0);
        count_up();
      end
    end else if (held) begin
      held = 1'b0;
      if (is_accent_upper(b) || is_accent_lower(b)) begin
        add_letter(LEAD_BYTE, b, 1'b1, is_accent_upper(b), is_accent_lower(b));
      end else begin
        add_symbol(LEAD_BYTE);
        plain_byte(b);
      end
    end else begin
      plain_byte(b);
    end
    n = (step_n > 3) ? 3 : step_n;
    if (step_n > 3) begin
      spill_rec = step_recs[3];
      spill_ok  = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      d.rec  = step_recs[k];
      d.last = (k == n - 1);
      due_records.push_back(d);
    end
  endfunction

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (got !== want) begin
      $error("%s expected 'h%0h actual 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    due_rec_t head;
    if (rst) begin
      mode      = MODE_IDLE;
      held      = 1'b0;
      count     = '0;
      up        = 1'b0;
      lo        = 1'b0;
      sent      = 1'b0;
      closing   = 1'b0;
      spill_ok  = 1'b0;
      spill_rec = '0;
      due_records.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_records.size() == 0) begin
          $error("record beat with nothing expected: kind %0d byte 'h%0h", record_kind,
                 out_byte);
          mismatches++;
        end else begin
          head = due_records.pop_front();
          check_field("record_kind", 12'(head.rec.kind), 12'(record_kind));
          check_field("out_byte", 12'(head.rec.data), 12'(out_byte));
          check_field("token_kind", 12'(head.rec.tkind), 12'(token_kind));
          check_field("case_class", 12'(head.rec.cclass), 12'(case_class));
          check_field("token_length", head.rec.len, token_length);
          check_field("last", 12'(head.last), 12'(last));
        end
      end
      if (in_valid && !in_stall) lex_step(in_byte, end_of_stream);
    end
    pending    <= due_records.size();
    fail_count <= mismatches;
  end

endmodule

// File: tb/markup_word_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_word_tokenizer_tb
// Drives byte beats into the tokenizer: a directed text with every token
// kind and corner, then random token sequences with noise, under random
// idling on both sides.
// ----------------------------------------------------------------------------
module markup_word_tokenizer_tb;
  import mwt_pkg::*;

  localparam int RANDOM_ITEMS   = 200;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte       = 8'h00;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic        record_kind;
  logic [7:0]  out_byte;
  logic [1:0]  token_kind;
  logic [1:0]  case_class;
  logic [11:0] token_length;
  logic        last;

  int          pending;
  int          fail_count;
  int          items_sent  = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  logic        quiet       = 1'b0;
  logic        paused      = 1'b0;

  always #1 clk = ~clk;

  markup_word_tokenizer i_dut (.*);

  mwt_checker i_checker (.*);

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("markup_word_tokenizer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic eos);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic logic [7:0] accent_byte(input logic upper, input int idx);
    logic [7:0] b;
    case (idx)
      0:       b = 8'h81;
      1:       b = 8'h89;
      2:       b = 8'h8D;
      3:       b = 8'h93;
      4:       b = 8'h9A;
      5:       b = 8'h9C;
      default: b = 8'h91;
    endcase
    return upper ? b : b + 8'h20;
  endfunction

  function automatic logic [7:0] symbol_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while ((b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z) ||
           b == CH_LT || b == LEAD_BYTE)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_letter(input logic upper);
    if ($urandom_range(0, 3) == 0) begin
      send_beat(LEAD_BYTE, 1'b0);
      send_beat(accent_byte(upper, $urandom_range(0, 6)), 1'b0);
    end else begin
      send_beat((upper ? CH_UP_A : CH_LO_A) + 8'($urandom_range(0, 25)), 1'b0);
    end
  endtask

  task automatic send_random_token();
    int pick;
    int len;
    int style;
    logic [7:0] b;
    pick = $urandom_range(0, 19);
    if (pick <= 6) begin
      // style: all upper, all lower, sentence, random case
      len   = $urandom_range(1, 6);
      style = $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
        send_letter(style == 0 || (style == 2 && i == 0) ||
                    (style == 3 && $urandom_range(0, 1) == 1));
    end else if (pick <= 10) begin
      len = $urandom_range(1, 4);
      repeat (len) send_beat(symbol_byte(), 1'b0);
    end else if (pick <= 14) begin
      send_beat(CH_LT, 1'b0);
      if ($urandom_range(0, 2) == 0) send_beat(CH_SLASH, 1'b0);
      len = $urandom_range(0, 5);
      repeat (len) begin
        b = 8'($urandom_range(0, 255));
        while (b == CH_GT) b = 8'($urandom_range(0, 255));
        send_beat(b, 1'b0);
      end
      if ($urandom_range(0, 5) != 0) send_beat(CH_GT, 1'b0);
    end else if (pick <= 16) begin
      send_beat(LEAD_BYTE, 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick <= 18) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_beat(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // upper word, extreme bytes, sentence word with accents, mixed word
    send_beat("A", 1'b0);       send_beat("B", 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(LEAD_BYTE, 1'b0); send_beat(8'h91, 1'b0);
    send_beat("a", 1'b0);
    send_beat(LEAD_BYTE, 1'b0); send_beat(8'hA1, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat("x", 1'b0);       send_beat("Y", 1'b0);
    // word, lone lead byte, letter: four records
    send_beat(LEAD_BYTE, 1'b0); send_beat("z", 1'b0);
    // lone lead byte before a symbol, stray closing bracket
    send_beat(LEAD_BYTE, 1'b0); send_beat("!", 1'b0);
    send_beat(CH_GT, 1'b0);
    // end command with a lead byte inside, empty command, unclosed command
    send_beat(CH_LT, 1'b0);     send_beat(CH_SLASH, 1'b0);
    send_beat("b", 1'b0);       send_beat(LEAD_BYTE, 1'b0);
    send_beat(CH_GT, 1'b0);
    send_beat(CH_LT, 1'b0);     send_beat(CH_GT, 1'b0);
    send_beat(CH_LT, 1'b0);     send_beat("p", 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    // held lead byte at end of stream
    send_beat(LEAD_BYTE, 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);

    while (items_sent < RANDOM_ITEMS) begin
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (items_sent >= RANDOM_ITEMS * 4 / 5) quiet <= 1'b1;
      send_random_token();
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("markup_word_tokenizer regression: pass");
    else
      $display("markup_word_tokenizer regression: fail");
    $finish;
  end

endmodule

// File: files.f
src/mwt_pkg.sv
src/mwt_step.sv
src/mwt_out.sv
src/markup_word_tokenizer.sv
tb/mwt_checker.sv
tb/markup_word_tokenizer_tb.sv
